>>> hdl/image_charge_coulomb_accel_assert.svh
// Assertion macros for the image-charge Coulomb accelerator.
`ifndef IMAGE_CHARGE_COULOMB_ACCEL_ASSERT_SVH
`define IMAGE_CHARGE_COULOMB_ACCEL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ICC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("image charge accelerator assertion failed");

// Next-cycle implication, disabled during reset.
`define ICC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("image charge accelerator assertion failed");

`endif

>>> hdl/icca_pkg.sv
// Shared constants and types of the image-charge Coulomb accelerator.
`default_nettype none
package icca_pkg;
    localparam int MAX_IMAGES = 16;
    localparam int CNT_W      = $clog2(MAX_IMAGES + 1);
    localparam int IDX_W      = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;

    localparam int S_TDATA_W  = 136;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 144;
    localparam int IMG_W      = 112;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;
endpackage
`default_nettype wire

>>> hdl/image_charge_coulomb_accel.sv
// Image-charge Coulomb accelerator: image table memory and force summation sequencer.
// Clear and append words are handled in the idle state. A query walks the stored images one by one
// (an image at zero distance is skipped after its sum of squares): 21 passes through one 33x33
// multiplier, a square root two radicand bits at a time, and a 128-step radix-2 division run for
// the three axes in parallel against a shared denominator. One word is processed at a time.
// Reset (synchronous, active low) empties the table, sets k to 1.0 and drops any pending
// result; the table memory itself is not cleared.
`default_nettype none
`include "image_charge_coulomb_accel_assert.svh"
module image_charge_coulomb_accel (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [31:0]                   cfg_wdata,   // coulomb_constant
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, charge, inv_mass
    input  wire logic [icca_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  wire logic [icca_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // acc_x, acc_y, acc_z
    output logic [icca_pkg::M_TDATA_W-1:0]     m_tdata
);
    import icca_pkg::*;

    localparam logic [4:0] STEP_K      = 5'd3;
    localparam logic [4:0] STEP_MI0    = 5'd4;
    localparam logic [4:0] STEP_NUM0   = 5'd7;
    localparam logic [4:0] STEP_A_LAST = 5'd18;
    localparam logic [4:0] STEP_DEN0   = 5'd19;
    localparam logic [4:0] STEP_DEN1   = 5'd20;
    localparam logic [6:0] SQRT_LAST   = 7'd33;
    localparam logic [6:0] DIV_LAST    = 7'd127;
    localparam logic [48:0] CLIP       = 49'h1_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_DIFF, ST_MULA, ST_CHECK, ST_SQRT,
        ST_MULB, ST_DRAIN, ST_DIV, ST_ACC, ST_DONE
    } state_t;

    state_t state_reg;

    logic [IMG_W-1:0] mem [MAX_IMAGES];
    logic [IMG_W-1:0] rd_data_reg;

    logic [CNT_W-1:0] count_reg, j_reg;
    logic [31:0]      k_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] qp_reg;
    logic [23:0]      invm_reg;

    logic [32:0]  m_reg [3];
    logic         dneg_reg [3];
    logic [30:0]  qq_abs_reg;
    logic         qq_neg_reg;

    logic [4:0]   step_reg, acc_step_reg;
    logic         acc_en_reg;
    logic [65:0]  mul_p_reg;
    logic [32:0]  mul_a, mul_b;

    logic [65:0]  s_reg;
    logic [61:0]  c_reg;
    logic [56:0]  mi_reg [3];
    logic [119:0] num_reg [3];
    logic [98:0]  den_reg;
    logic [32:0]  r_reg;

    logic [67:0]  sq_src_reg;
    logic [33:0]  root_reg;
    logic [34:0]  sq_rem_reg;
    logic [6:0]   cnt_reg;

    logic [98:0]  rem_reg [3];
    logic [48:0]  q_reg [3];
    logic         ovf_reg [3];

    logic signed [53:0] acc_reg [3];
    logic         m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Operand selection for the shared multiplier.
    logic [4:0] sub;
    logic [1:0] ax, pt;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sub   = step_reg - STEP_NUM0;
        ax    = sub[3:2];
        pt    = sub[1:0];
        if (step_reg < STEP_K) begin
            mul_a = m_reg[step_reg[1:0]];
            mul_b = m_reg[step_reg[1:0]];
        end else if (step_reg == STEP_K) begin
            mul_a = {1'b0, k_reg};
            mul_b = {2'b0, qq_abs_reg};
        end else if (step_reg < STEP_NUM0) begin
            mul_a = m_reg[2'(step_reg - STEP_MI0)];
            mul_b = {9'b0, invm_reg};
        end else if (step_reg <= STEP_A_LAST) begin
            mul_a = pt[1] ? {4'b0, c_reg[61:33]} : c_reg[32:0];
            mul_b = pt[0] ? {9'b0, mi_reg[ax][56:33]} : mi_reg[ax][32:0];
        end else if (step_reg == STEP_DEN0) begin
            mul_a = s_reg[32:0];
            mul_b = r_reg;
        end else begin
            mul_a = s_reg[65:33];
            mul_b = r_reg;
        end
    end

    // Square root step: two radicand bits per cycle.
    logic [36:0] sq_rem_sh, sq_trial;
    logic        sq_ge;
    logic [33:0] root_next;
    always_comb begin
        sq_rem_sh = {sq_rem_reg, sq_src_reg[67:66]};
        sq_trial  = {1'b0, root_reg, 2'b01};
        sq_ge     = sq_rem_sh >= sq_trial;
        root_next = {root_reg[32:0], sq_ge};
    end

    // Divider step for the three axes against the shared denominator.
    logic [99:0] rem_sh [3];
    logic        div_ge [3];
    logic [48:0] term [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rem_sh[a] = {rem_reg[a], num_reg[a][119]};
            div_ge[a] = rem_sh[a] >= {1'b0, den_reg};
            term[a]   = (ovf_reg[a] || q_reg[a] > CLIP) ? CLIP : q_reg[a];
        end
    end

    logic [CNT_W-1:0] j_next;
    assign j_next = j_reg + 1'b1;

    function automatic logic [47:0] sat48(input logic signed [53:0] v);
        if (v > 54'sd140737488355327)
            return 48'h7FFF_FFFF_FFFF;
        else if (v < -54'sd140737488355328)
            return 48'h8000_0000_0000;
        else
            return v[47:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn)
            k_reg <= 32'd65536;
        else if (cfg_we)
            k_reg <= cfg_wdata;
        if (state_reg == ST_IDLE && s_tvalid && cmd_t'(s_tuser) == CMD_APPEND &&
            count_reg < CNT_W'(MAX_IMAGES))
            mem[count_reg[IDX_W-1:0]] <= s_tdata[IMG_W-1:0];
        rd_data_reg <= mem[j_reg[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            acc_en_reg   <= 1'b0;
        end else begin
            mul_p_reg    <= {33'b0, mul_a} * {33'b0, mul_b};
            acc_step_reg <= step_reg;
            acc_en_reg   <= (state_reg == ST_MULA) || (state_reg == ST_MULB);

            if (acc_en_reg) begin
                if (acc_step_reg < STEP_K) begin
                    s_reg <= s_reg + mul_p_reg;
                end else if (acc_step_reg == STEP_K) begin
                    c_reg <= mul_p_reg[61:0];
                end else if (acc_step_reg < STEP_NUM0) begin
                    mi_reg[2'(acc_step_reg - STEP_MI0)] <= mul_p_reg[56:0];
                end else if (acc_step_reg <= STEP_A_LAST) begin
                    case (2'(acc_step_reg - STEP_NUM0))
                        2'd0:    num_reg[2'((acc_step_reg - STEP_NUM0) >> 2)] <=
                                     num_reg[2'((acc_step_reg - STEP_NUM0) >> 2)] +
                                     120'(mul_p_reg);
                        2'd3:    num_reg[2'((acc_step_reg - STEP_NUM0) >> 2)] <=
                                     num_reg[2'((acc_step_reg - STEP_NUM0) >> 2)] +
                                     (120'(mul_p_reg) << 66);
                        default: num_reg[2'((acc_step_reg - STEP_NUM0) >> 2)] <=
                                     num_reg[2'((acc_step_reg - STEP_NUM0) >> 2)] +
                                     (120'(mul_p_reg) << 33);
                    endcase
                end else if (acc_step_reg == STEP_DEN0) begin
                    den_reg <= den_reg + 99'(mul_p_reg);
                end else begin
                    den_reg <= den_reg + (99'(mul_p_reg) << 33);
                end
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_DONE)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        case (cmd_t'(s_tuser))
                            CMD_CLEAR:  count_reg <= '0;
                            CMD_APPEND: begin
                                if (count_reg < CNT_W'(MAX_IMAGES))
                                    count_reg <= count_reg + 1'b1;
                            end
                            CMD_QUERY: begin
                                px_reg   <= s_tdata[31:0];
                                py_reg   <= s_tdata[63:32];
                                pz_reg   <= s_tdata[95:64];
                                qp_reg   <= s_tdata[111:96];
                                invm_reg <= s_tdata[135:112];
                                j_reg    <= '0;
                                for (int a = 0; a < 3; a++)
                                    acc_reg[a] <= '0;
                                state_reg <= (count_reg == '0) ? ST_DONE : ST_FETCH;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FETCH: state_reg <= ST_DIFF;
                ST_DIFF: begin
                    logic signed [32:0] d;
                    logic signed [31:0] qq;
                    for (int a = 0; a < 3; a++) begin
                        d = 33'($signed(rd_data_reg[32*a +: 32])) -
                            33'(a == 0 ? px_reg : (a == 1 ? py_reg : pz_reg));
                        dneg_reg[a] <= d[32];
                        m_reg[a]    <= d[32] ? 33'(-d) : 33'(d);
                        num_reg[a]  <= '0;
                    end
                    qq = $signed(rd_data_reg[111:96]) * qp_reg;
                    qq_neg_reg <= qq[31];
                    qq_abs_reg <= qq[31] ? 31'(-qq) : 31'(qq);
                    s_reg     <= '0;
                    den_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_MULA;
                end
                ST_MULA: begin
                    if (step_reg == STEP_A_LAST)
                        state_reg <= ST_CHECK;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_CHECK: begin
                    if (s_reg == '0) begin
                        // An image at the particle's own position adds nothing.
                        j_reg     <= j_next;
                        state_reg <= (j_next == count_reg) ? ST_DONE : ST_FETCH;
                    end else begin
                        sq_src_reg <= {2'b00, s_reg};
                        root_reg   <= '0;
                        sq_rem_reg <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    sq_src_reg <= {sq_src_reg[65:0], 2'b00};
                    sq_rem_reg <= sq_ge ? 35'(sq_rem_sh - sq_trial) : sq_rem_sh[34:0];
                    root_reg   <= root_next;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == SQRT_LAST) begin
                        r_reg     <= root_next[32:0];
                        step_reg  <= STEP_DEN0;
                        state_reg <= ST_MULB;
                    end
                end
                ST_MULB: begin
                    if (step_reg == STEP_DEN1)
                        state_reg <= ST_DRAIN;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_DRAIN: begin
                    for (int a = 0; a < 3; a++) begin
                        rem_reg[a] <= '0;
                        q_reg[a]   <= '0;
                        ovf_reg[a] <= 1'b0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // The numerator shifts out MSB first; zeros follow for the last eight bits.
                    for (int a = 0; a < 3; a++) begin
                        num_reg[a] <= {num_reg[a][118:0], 1'b0};
                        rem_reg[a] <= div_ge[a] ? 99'(rem_sh[a] - {1'b0, den_reg})
                                                : rem_sh[a][98:0];
                        q_reg[a]   <= {q_reg[a][47:0], div_ge[a]};
                        ovf_reg[a] <= ovf_reg[a] | q_reg[a][48];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    for (int a = 0; a < 3; a++) begin
                        if (qq_neg_reg != dneg_reg[a])
                            acc_reg[a] <= acc_reg[a] + $signed(54'(term[a]));
                        else
                            acc_reg[a] <= acc_reg[a] - $signed(54'(term[a]));
                    end
                    j_reg     <= j_next;
                    state_reg <= (j_next == count_reg) ? ST_DONE : ST_FETCH;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {sat48(acc_reg[2]), sat48(acc_reg[1]),
                                         sat48(acc_reg[0])};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ICC_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_IMAGES))
    `ICC_ASSERT_IMPL(a_fetch_in_table, aclk, aresetn, state_reg == ST_FETCH, j_reg < count_reg)
    `ICC_ASSERT_IMPL(a_den_nonzero, aclk, aresetn, state_reg == ST_DIV, den_reg != '0)
    `ICC_ASSERT_NEXT(a_result_from_done, aclk, aresetn,
        state_reg != ST_DONE && !m_tvalid_reg, !m_tvalid_reg)
endmodule
`default_nettype wire
